// File: src/blfc_pkg.sv
// Shared types, constants and CRC helpers for the binary log frame checker.
`timescale 1ns / 1ps

package blfc_pkg;

    localparam logic [7:0]  SYNC0          = 8'hAA;
    localparam logic [7:0]  SYNC1          = 8'h44;
    localparam logic [7:0]  SYNC2          = 8'h12;
    localparam logic [16:0] HEADER_BYTES   = 17'd28;
    localparam logic [17:0] HEADER_CRC     = 18'd32;
    localparam logic [16:0] COUNT_MAX      = 17'h1FFFF;
    localparam logic [31:0] CRC_POLY_RESET = 32'hEDB88320;

    localparam logic [15:0] ID_RANGE    = 16'd43;
    localparam logic [15:0] ID_GPS_EPH  = 16'd7;
    localparam logic [15:0] ID_BDS_EPH  = 16'd1696;
    localparam logic [15:0] ID_POSITION = 16'd42;

    localparam logic CFG_IDX_CRC_POLY = 1'b0;

    typedef enum logic [1:0] {
        ST_OK,
        ST_SHORT_HEADER,
        ST_SHORT_BODY,
        ST_CRC_BAD
    } t_status;

    typedef enum logic [2:0] {
        KIND_RANGE,
        KIND_GPS_EPH,
        KIND_BDS_EPH,
        KIND_POSITION,
        KIND_OTHER
    } t_kind;

    typedef struct packed {
        t_status     status;
        logic [15:0] message_id;
        logic [15:0] payload_length;
        t_kind       kind;
    } t_frame_result;

    function automatic logic [31:0] crc_shift(input logic [31:0] c_in,
                                              input logic [31:0] poly,
                                              input int unsigned n);
        logic [31:0] c;
        c = c_in;
        for (int k = 0; k < 8; k++) begin
            if (k < n) begin
                c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
            end
        end
        return c;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in,
                                             input logic [7:0]  b,
                                             input logic [31:0] poly);
        return crc_shift(c_in ^ {24'd0, b}, poly, 8);
    endfunction

    localparam logic [31:0] SYNC_CRC_RESET =
        crc_byte(crc_byte(crc_byte(32'd0, SYNC0, CRC_POLY_RESET),
                          SYNC1, CRC_POLY_RESET), SYNC2, CRC_POLY_RESET);

    function automatic t_kind kind_of(input logic [15:0] id);
        t_kind k;
        case (id)
            ID_RANGE:    k = KIND_RANGE;
            ID_GPS_EPH:  k = KIND_GPS_EPH;
            ID_BDS_EPH:  k = KIND_BDS_EPH;
            ID_POSITION: k = KIND_POSITION;
            default:     k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

// File: src/blfc_seg.sv
// Segment tracker: sync search, header capture, CRC and frame check.
`timescale 1ns / 1ps

module blfc_seg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [7:0]             i_byte,
    input  logic [31:0]            i_poly,
    input  logic [31:0]            i_sync_crc,
    output logic                   o_emit,
    output blfc_pkg::t_frame_result o_result
);
    import blfc_pkg::*;

    logic [15:0] r_hist, n_hist;
    logic        r_in_seg, n_in_seg;
    logic [16:0] r_count, n_count;
    logic [31:0] r_crc, n_crc;
    logic [15:0] r_len, n_len;
    logic [15:0] r_id, n_id;
    logic [31:0] r_rx_crc, n_rx_crc;

    logic        sync;
    logic [16:0] body;
    logic [16:0] off;
    logic [16:0] seg_len;
    t_status     status;

    always_comb begin
        sync    = (r_hist == {SYNC0, SYNC1}) && (i_byte == SYNC2);
        body    = {1'b0, r_len} + HEADER_BYTES;
        off     = r_count - body;
        seg_len = (r_count == COUNT_MAX) ? COUNT_MAX : (r_count - 17'd2);

        if (seg_len < HEADER_BYTES) begin
            status = ST_SHORT_HEADER;
        end else if ({1'b0, seg_len} < ({2'b00, r_len} + HEADER_CRC)) begin
            status = ST_SHORT_BODY;
        end else if (r_crc != r_rx_crc) begin
            status = ST_CRC_BAD;
        end else begin
            status = ST_OK;
        end

        o_emit                  = sync && r_in_seg;
        o_result.status         = status;
        o_result.message_id     = r_id;
        o_result.payload_length = r_len;
        o_result.kind           = kind_of(r_id);

        n_hist   = {r_hist[7:0], i_byte};
        n_in_seg = r_in_seg;
        n_count  = r_count;
        n_crc    = r_crc;
        n_len    = r_len;
        n_id     = r_id;
        n_rx_crc = r_rx_crc;

        if (sync) begin
            // restart: the three sync bytes are already folded in
            n_in_seg = 1'b1;
            n_count  = 17'd3;
            n_crc    = i_sync_crc;
            n_len    = '0;
            n_id     = '0;
            n_rx_crc = '0;
        end else if (r_in_seg) begin
            if (r_count == 17'd4) n_id[7:0]   = i_byte;
            if (r_count == 17'd5) n_id[15:8]  = i_byte;
            if (r_count == 17'd8) n_len[7:0]  = i_byte;
            if (r_count == 17'd9) n_len[15:8] = i_byte;
            if (r_count < body) begin
                n_crc = crc_byte(r_crc, i_byte, i_poly);
            end else if (off < 17'd4) begin
                case (off[1:0])
                    2'd0:    n_rx_crc[7:0]   = r_rx_crc[7:0]   | i_byte;
                    2'd1:    n_rx_crc[15:8]  = r_rx_crc[15:8]  | i_byte;
                    2'd2:    n_rx_crc[23:16] = r_rx_crc[23:16] | i_byte;
                    default: n_rx_crc[31:24] = r_rx_crc[31:24] | i_byte;
                endcase
            end
            if (r_count != COUNT_MAX) n_count = r_count + 17'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist   <= '0;
            r_in_seg <= 1'b0;
            r_count  <= '0;
            r_crc    <= '0;
            r_len    <= '0;
            r_id     <= '0;
            r_rx_crc <= '0;
        end else if (i_step) begin
            r_hist   <= n_hist;
            r_in_seg <= n_in_seg;
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_len    <= n_len;
            r_id     <= n_id;
            r_rx_crc <= n_rx_crc;
        end
    end

endmodule

// File: src/binary_log_frame_checker_unit.sv
// Top level of the binary log frame checker with its register port.
`timescale 1ns / 1ps

// Takes one byte of a receiver log stream per request and reports one result per
// segment delimited by the sync AA 44 12: status, message id, payload length and
// message kind, issued when the sync that closes the segment completes. A byte is
// accepted every cycle unless the input is held; it waits in the input register, is
// folded into the segment state by an unrolled 8-bit CRC update and, on a closing
// sync, lands from there in the result register. Only a result waiting on a full
// result register holds the input; other bytes keep flowing. The CRC of the sync
// bytes is prepared during the setup and access cycles of a polynomial write.
module binary_log_frame_checker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_frame_status,
    output logic [15:0] o_message_id,
    output logic [15:0] o_payload_length,
    output logic [2:0]  o_message_kind,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import blfc_pkg::*;

    logic [31:0]   r_poly;
    logic [31:0]   r_crc_half;
    logic [31:0]   r_sync_crc;
    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_out_valid;
    t_frame_result r_out;

    logic          cfg_sel;
    logic          fire;
    logic          emit;
    t_frame_result result;

    assign pready  = 1'b1;
    assign cfg_sel = psel && pwrite && (paddr[2] == CFG_IDX_CRC_POLY);
    assign prdata  = (paddr[2] == CFG_IDX_CRC_POLY) ? r_poly : 32'd0;

    // fold in the first byte and a half of the sync during setup
    always_ff @(posedge i_clk) begin
        if (cfg_sel && !penable) begin
            r_crc_half <= crc_shift(crc_byte(32'd0, SYNC0, pwdata) ^ {24'd0, SYNC1},
                                    pwdata, 4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly     <= CRC_POLY_RESET;
            r_sync_crc <= SYNC_CRC_RESET;
        end else if (cfg_sel && penable && pready) begin
            r_poly     <= pwdata;
            r_sync_crc <= crc_byte(crc_shift(r_crc_half, pwdata, 4), SYNC2, pwdata);
        end
    end

    assign fire    = r_in_valid && (!emit || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_data_byte;
        end
    end

    blfc_seg u_seg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (fire),
        .i_byte     (r_in_byte),
        .i_poly     (r_poly),
        .i_sync_crc (r_sync_crc),
        .o_emit     (emit),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out <= result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_frame_status   = r_out.status;
    assign o_message_id     = r_out.message_id;
    assign o_payload_length = r_out.payload_length;
    assign o_message_kind   = r_out.kind;

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fire && emit && r_out_valid && !i_ready))
        else $error("result register overwritten while full");

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid && $stable(r_in_byte))
        else $error("pending byte lost from input register");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_message_kind == KIND_RANGE) == (o_message_id == ID_RANGE)))
        else $error("message kind does not match message id");

    a_kind_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_message_kind == KIND_OTHER) |->
            (o_message_id != ID_RANGE) && (o_message_id != ID_GPS_EPH) &&
            (o_message_id != ID_BDS_EPH) && (o_message_id != ID_POSITION))
        else $error("known message id reported as other");

endmodule
